// ===== design/vpa_pkg.sv =====
// vpa_pkg: shared constants, CORDIC arctangent table and control struct
// for the vector pair angle pipeline. No dependencies.
package vpa_pkg;

    // datapath widths
    localparam int XY_W     = 64;   // CORDIC x/y, signed
    localparam int Z_W      = 34;   // angle accumulator, signed Q.30 radians
    localparam int NORM_W   = 60;   // normalized operand, leading one at bit 59
    localparam int ZC_W     = 32;   // clamped angle, unsigned Q.30
    localparam int ANGLE_W  = 16;   // result angle
    localparam int ATAN_W   = 30;
    localparam int ATAN_LEN = 24;
    localparam int DEG_W    = 30;
    localparam int PROD_W   = ZC_W + DEG_W;
    localparam int RAD_FRAC = 16;   // Q.30 -> Q2.14
    localparam int DEG_FRAC = 46;   // Q.30 * Q.24 -> Q8.8

    // round(atan(2^-i) * 2^30)
    localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    localparam logic [ZC_W-1:0]  HALF_PI_Q30     = 32'd1686629713;
    localparam logic [ZC_W-1:0]  PI_Q30          = 32'd3373259426;
    localparam logic [DEG_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;

    // per-beat control traveling alongside the datapath
    typedef struct packed {
        logic valid;
        logic degen;   // either vector is (0,0)
        logic neg;     // dot product below zero
    } t_ctl;

endpackage

// ===== design/vpa_front.sv =====
// vpa_front: two-stage front end forming |dot| and |cross| of the vector pair.
// Depends on vpa_pkg.
module vpa_front import vpa_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [COORD_WIDTH-1:0]  i_ax,
    input  logic signed [COORD_WIDTH-1:0]  i_ay,
    input  logic signed [COORD_WIDTH-1:0]  i_bx,
    input  logic signed [COORD_WIDTH-1:0]  i_by,
    output t_ctl                           o_ctl,
    output logic [2*COORD_WIDTH-1:0]       o_dot_mag,
    output logic [2*COORD_WIDTH-1:0]       o_cross_mag
);

    localparam int P_W = 2 * COORD_WIDTH;
    localparam int S_W = P_W + 1;

    t_ctl                   r_a_ctl, n_a_ctl, r_b_ctl, n_b_ctl;
    logic signed [P_W-1:0]  r_p_axbx, r_p_ayby, r_p_axby, r_p_aybx;
    logic signed [P_W-1:0]  n_p_axbx, n_p_ayby, n_p_axby, n_p_aybx;
    logic signed [S_W-1:0]  dot, cross_sum, dot_neg, cross_neg;
    logic [P_W-1:0]         r_dot_mag, r_cross_mag, n_dot_mag, n_cross_mag;

    // stage A: four signed products, zero-vector detect
    always_comb begin
        n_a_ctl.valid = i_valid;
        n_a_ctl.degen = ((i_ax == '0) && (i_ay == '0)) || ((i_bx == '0) && (i_by == '0));
        n_a_ctl.neg   = 1'b0;
    end
    assign n_p_axbx = P_W'(i_ax) * P_W'(i_bx);
    assign n_p_ayby = P_W'(i_ay) * P_W'(i_by);
    assign n_p_axby = P_W'(i_ax) * P_W'(i_by);
    assign n_p_aybx = P_W'(i_ay) * P_W'(i_bx);

    // stage B: exact dot and cross, then magnitudes
    assign dot         = S_W'(r_p_axbx) + S_W'(r_p_ayby);
    assign cross_sum   = S_W'(r_p_axby) - S_W'(r_p_aybx);
    assign dot_neg     = -dot;
    assign cross_neg   = -cross_sum;
    assign n_dot_mag   = dot[S_W-1]       ? dot_neg[P_W-1:0]   : dot[P_W-1:0];
    assign n_cross_mag = cross_sum[S_W-1] ? cross_neg[P_W-1:0] : cross_sum[P_W-1:0];
    always_comb begin
        n_b_ctl     = r_a_ctl;
        n_b_ctl.neg = dot[S_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
            r_b_ctl <= n_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_axbx    <= n_p_axbx;
            r_p_ayby    <= n_p_ayby;
            r_p_axby    <= n_p_axby;
            r_p_aybx    <= n_p_aybx;
            r_dot_mag   <= n_dot_mag;
            r_cross_mag <= n_cross_mag;
        end
    end

    assign o_ctl       = r_b_ctl;
    assign o_dot_mag   = r_dot_mag;
    assign o_cross_mag = r_cross_mag;

endmodule

// ===== design/vpa_norm_cell.sv =====
// vpa_norm_cell: one step of the normalizing shifter; shifts both operands
// left by SHIFT when their top SHIFT bits are all clear. Depends on vpa_pkg.
module vpa_norm_cell import vpa_pkg::*; #(
    parameter int FRAME_W = 92,
    parameter int SHIFT   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_ctl               i_ctl,
    input  logic [FRAME_W-1:0] i_dot,
    input  logic [FRAME_W-1:0] i_cross,
    output t_ctl               o_ctl,
    output logic [FRAME_W-1:0] o_dot,
    output logic [FRAME_W-1:0] o_cross
);

    t_ctl               r_ctl;
    logic [FRAME_W-1:0] r_dot, r_cross, n_dot, n_cross;
    logic               do_shift;

    // the larger operand decides; its top bits are clear iff both are
    assign do_shift = (i_dot[FRAME_W-1 -: SHIFT] | i_cross[FRAME_W-1 -: SHIFT]) == '0;
    assign n_dot    = do_shift ? (i_dot << SHIFT)   : i_dot;
    assign n_cross  = do_shift ? (i_cross << SHIFT) : i_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot   <= n_dot;
            r_cross <= n_cross;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_dot   = r_dot;
    assign o_cross = r_cross;

endmodule

// ===== design/vpa_cordic_cell.sv =====
// vpa_cordic_cell: one vectoring CORDIC micro-rotation, driving y toward zero
// and accumulating the angle. Depends on vpa_pkg.
module vpa_cordic_cell import vpa_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_ctl                   i_ctl,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    output t_ctl                   o_ctl,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] STEP_ANGLE = {{(Z_W-ATAN_W){1'b0}}, ATAN_Q30[SHIFT]};

    t_ctl                   r_ctl;
    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y, dx, dy;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic                   y_pos;

    // arithmetic shifts round toward minus infinity
    assign dx    = i_y >>> SHIFT;
    assign dy    = i_x >>> SHIFT;
    assign y_pos = !i_y[XY_W-1] && (i_y != '0);
    assign n_x   = y_pos ? (i_x + dx) : (i_x - dx);
    assign n_y   = y_pos ? (i_y - dy) : (i_y + dy);
    assign n_z   = y_pos ? (i_z + STEP_ANGLE) : (i_z - STEP_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== design/vpa_scale.sv =====
// vpa_scale: clamps the CORDIC angle to [0, pi] and converts it to Q2.14
// radians or Q8.8 degrees over three stages. Depends on vpa_pkg.
module vpa_scale import vpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_in_degrees,
    input  t_ctl                  i_ctl,
    input  logic signed [Z_W-1:0] i_z,
    output t_ctl                  o_ctl,
    output logic [ANGLE_W-1:0]    o_angle
);

    t_ctl                r_c_ctl, r_m_ctl, r_o_ctl;
    logic [ZC_W-1:0]     r_zc, n_zc, zc_rnd;
    logic [PROD_W-1:0]   r_prod, n_prod, prod_rnd;
    logic [ANGLE_W-1:0]  r_rad, n_rad, r_angle, n_angle;

    // stage 1: clamp
    always_comb begin
        if (i_z[Z_W-1]) begin
            n_zc = '0;
        end else if (i_z > Z_W'(PI_Q30)) begin
            n_zc = PI_Q30;
        end else begin
            n_zc = i_z[ZC_W-1:0];
        end
    end

    // stage 2: degree product, rounded radians
    assign n_prod = PROD_W'(r_zc) * PROD_W'(DEG_PER_RAD_Q24);
    assign zc_rnd = r_zc + (ZC_W'(1) << (RAD_FRAC - 1));
    assign n_rad  = zc_rnd[RAD_FRAC +: ANGLE_W];

    // stage 3: round degrees, select unit, zero for a degenerate pair
    assign prod_rnd = r_prod + (PROD_W'(1) << (DEG_FRAC - 1));
    always_comb begin
        if (r_m_ctl.degen) begin
            n_angle = '0;
        end else if (i_in_degrees) begin
            n_angle = prod_rnd[DEG_FRAC +: ANGLE_W];
        end else begin
            n_angle = r_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
            r_m_ctl <= '0;
            r_o_ctl <= '0;
        end else if (i_en) begin
            r_c_ctl <= i_ctl;
            r_m_ctl <= r_c_ctl;
            r_o_ctl <= r_m_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zc    <= n_zc;
            r_prod  <= n_prod;
            r_rad   <= n_rad;
            r_angle <= n_angle;
        end
    end

    assign o_ctl   = r_o_ctl;
    assign o_angle = r_angle;

endmodule

// ===== design/vector_pair_angle.sv =====
// vector_pair_angle: unsigned angle between two 2D integer vectors via a
// pipelined vectoring CORDIC. Depends on vpa_pkg, vpa_front, vpa_norm_cell,
// vpa_cordic_cell and vpa_scale.
//
//   channel   direction  signals                      content
//   s_axis    in         tvalid/tready/tdata          first_x, first_y, second_x, second_y
//   m_axis    out        tvalid/tready/tdata/tuser    angle; tuser = degenerate
//   cfg       in         i_cfg_we/i_cfg_wdata         in_degrees
//
// One beat is taken per clock while s_axis_tready is high; each passes the front end,
// normalizer, CORDIC start register, CORDIC cell chain, vpa_scale and output register.
// Reset clears all valid flags and selects radians; no clearing pass is needed.
// A result held by m_axis stall parks in a skid register; s_axis_tready drops only
// while the skid register is full, and the whole pipeline then holds.
module vector_pair_angle import vpa_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16,
    localparam int S_TDATA_W    = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ANGLE_W-1:0]   m_axis_tdata,   // angle
    output logic                 m_axis_tuser    // degenerate
);

    localparam int MAG_W    = 2 * COORD_WIDTH;
    localparam int FRAME_W  = MAG_W + NORM_W;
    localparam int N_NORM   = $clog2(MAG_W);
    localparam int N_CELLS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic                   en, in_valid, move;
    logic                   r_in_degrees;

    t_ctl                   front_ctl;
    logic [MAG_W-1:0]       dot_mag, cross_mag;

    t_ctl                   norm_ctl   [N_NORM+1];
    logic [FRAME_W-1:0]     norm_dot   [N_NORM+1];
    logic [FRAME_W-1:0]     norm_cross [N_NORM+1];

    t_ctl                   r_init_ctl;
    logic signed [XY_W-1:0] r_init_x, r_init_y, n_init_x, n_init_y;
    logic signed [Z_W-1:0]  r_init_z, n_init_z;
    logic [NORM_W-1:0]      md_top, mc_top;

    t_ctl                   cell_ctl [N_CELLS+1];
    logic signed [XY_W-1:0] cell_x   [N_CELLS+1];
    logic signed [XY_W-1:0] cell_y   [N_CELLS+1];
    logic signed [Z_W-1:0]  cell_z   [N_CELLS+1];

    t_ctl                   pipe_ctl;
    logic [ANGLE_W-1:0]     pipe_angle;

    logic                   r_out_valid, r_skid_valid;
    logic [ANGLE_W-1:0]     r_out_angle, r_skid_angle;
    logic                   r_out_degen, r_skid_degen;

    // pipeline advances unless a result is parked in the skid register
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign in_valid      = s_axis_tvalid && en;
    assign move          = en && pipe_ctl.valid;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_degrees <= 1'b0;
        end else if (i_cfg_we) begin
            r_in_degrees <= i_cfg_wdata;
        end
    end

    // products, dot and cross
    vpa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (in_valid),
        .i_ax        (s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .i_ay        (s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .i_bx        (s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .i_by        (s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
        .o_ctl       (front_ctl),
        .o_dot_mag   (dot_mag),
        .o_cross_mag (cross_mag)
    );

    // normalizer: magnitudes sit on top of a zero-padded frame, shifted left
    // in halving steps until the larger one has its leading one at the top
    assign norm_ctl[0]   = front_ctl;
    assign norm_dot[0]   = {dot_mag, NORM_W'(0)};
    assign norm_cross[0] = {cross_mag, NORM_W'(0)};

    for (genvar k = 0; k < N_NORM; k++) begin : g_norm
        vpa_norm_cell #(.FRAME_W(FRAME_W), .SHIFT(2 ** (N_NORM - 1 - k))) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (norm_ctl[k]),
            .i_dot   (norm_dot[k]),
            .i_cross (norm_cross[k]),
            .o_ctl   (norm_ctl[k+1]),
            .o_dot   (norm_dot[k+1]),
            .o_cross (norm_cross[k+1])
        );
    end

    // CORDIC start: for an obtuse pair pre-rotate by -pi/2
    assign md_top   = norm_dot[N_NORM][FRAME_W-1 -: NORM_W];
    assign mc_top   = norm_cross[N_NORM][FRAME_W-1 -: NORM_W];
    assign n_init_x = norm_ctl[N_NORM].neg ? XY_W'(mc_top) : XY_W'(md_top);
    assign n_init_y = norm_ctl[N_NORM].neg ? XY_W'(md_top) : XY_W'(mc_top);
    assign n_init_z = norm_ctl[N_NORM].neg ? Z_W'(HALF_PI_Q30) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_ctl <= '0;
        end else if (en) begin
            r_init_ctl <= norm_ctl[N_NORM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_init_x <= n_init_x;
            r_init_y <= n_init_y;
            r_init_z <= n_init_z;
        end
    end

    // CORDIC cell chain
    assign cell_ctl[0] = r_init_ctl;
    assign cell_x[0]   = r_init_x;
    assign cell_y[0]   = r_init_y;
    assign cell_z[0]   = r_init_z;

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cordic
        vpa_cordic_cell #(.SHIFT(i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (cell_ctl[i]),
            .i_x     (cell_x[i]),
            .i_y     (cell_y[i]),
            .i_z     (cell_z[i]),
            .o_ctl   (cell_ctl[i+1]),
            .o_x     (cell_x[i+1]),
            .o_y     (cell_y[i+1]),
            .o_z     (cell_z[i+1])
        );
    end

    // clamp and unit conversion
    vpa_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_in_degrees (r_in_degrees),
        .i_ctl        (cell_ctl[N_CELLS]),
        .i_z          (cell_z[N_CELLS]),
        .o_ctl        (pipe_ctl),
        .o_angle      (pipe_angle)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= move;
            end
        end else if (move) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_angle <= r_skid_angle;
                r_out_degen <= r_skid_degen;
            end else if (move) begin
                r_out_angle <= pipe_angle;
                r_out_degen <= pipe_ctl.degen;
            end
        end else if (move) begin
            r_skid_angle <= pipe_angle;
            r_skid_degen <= pipe_ctl.degen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_angle;
    assign m_axis_tuser  = r_out_degen;

endmodule

// ===== design/vpa_checker.sv =====
// vpa_checker: port-level checks for vector_pair_angle, bound to the top level.
// Depends on nothing but the top level's port names.
module vpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // round(pi * 2^14), the largest angle in either unit
    localparam logic [15:0] ANGLE_MAX = 16'd51472;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // degenerate pair reports a zero angle
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate beat with nonzero angle");

    // angle never exceeds pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= ANGLE_MAX)
        else $error("angle beyond pi");

    // input back-pressure only while a result is waiting on the output
    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

endmodule

bind vector_pair_angle vpa_checker u_vpa_checker (.*);

// ===== dv/tb.sv =====
// tb: self-checking stream testbench for vector_pair_angle, with its own angle predictor.
// Depends on the design files under design/ (vpa_pkg and the vector_pair_angle top).
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vpa_pkg::*;

    localparam int IDLE_PCT     = 27;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 180;
    localparam int CORNER_COUNT = 22;
    localparam int SEND_CALM_LO = 400;    // sender never idles inside this item window
    localparam int SEND_CALM_HI = 560;
    localparam int RECV_CALM_LO = 420;    // receiver never stalls inside this result window
    localparam int RECV_CALM_HI = 600;
    localparam int HOLD_AT      = 250;    // long receiver hold-off starts after this result
    localparam int HOLD_CYCLES  = 300;

    // round(atan(2^-i) * 2^30) for the 16 rotations
    localparam longint ATAN_STEP [16] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687,  33543516,  16775851,  8388437,
        4194283,   2097149,   1048576,   524288,
        262144,    131072,    65536,     32768
    };
    localparam longint QUARTER_TURN  = 64'd1686629713;  // pi/2 in Q.30
    localparam longint HALF_TURN     = 64'd3373259426;  // pi in Q.30
    localparam longint DEG_SCALE_Q24 = 64'd961263669;   // 180/pi in Q.24

    // matches s_axis_tdata bit for bit: first_x lowest, second_y highest
    typedef struct packed {
        logic signed [15:0] by;
        logic signed [15:0] bx;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } pair_t;

    // expected angles for accepted vector pairs, oldest first
    class angle_scoreboard;
        typedef struct {
            logic [ANGLE_W-1:0] angle;
            logic               degen;
        } angle_res_t;

        bit         unit_deg;
        angle_res_t expected_angles [$];
        int         errors;

        static function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // sign-magnitude sum, sign of the result in sr
        static function longint unsigned sm_sum(bit sa, longint unsigned ma,
                                                bit sb, longint unsigned mb,
                                                output bit sr);
            if (sa == sb) begin
                sr = sa;
                return ma + mb;
            end
            if (ma >= mb) begin
                sr = sa;
                return ma - mb;
            end
            sr = sb;
            return mb - ma;
        endfunction

        function angle_res_t predict_angle(pair_t p);
            longint            ax, ay, bx, by, x, y, z, dx, dy;
            longint unsigned   md, mc, mm, zu, res;
            bit                sd, sc, neg;
            angle_res_t        r;
            ax = p.ax;
            ay = p.ay;
            bx = p.bx;
            by = p.by;
            if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
                r.angle = '0;
                r.degen = 1'b1;
                return r;
            end
            // exact dot and cross magnitudes
            md = sm_sum((ax < 0) != (bx < 0), magnitude(ax) * magnitude(bx),
                        (ay < 0) != (by < 0), magnitude(ay) * magnitude(by), sd);
            mc = sm_sum((ax < 0) != (by < 0), magnitude(ax) * magnitude(by),
                        !((ay < 0) != (bx < 0)), magnitude(ay) * magnitude(bx), sc);
            // normalize: larger magnitude into [2^59, 2^60); products stay below 2^32
            mm = (md > mc) ? md : mc;
            while (mm < (64'd1 << 59)) begin
                md = md << 1;
                mc = mc << 1;
                mm = mm << 1;
            end
            // obtuse case: pre-rotate by -pi/2
            neg = sd && (md != 0);
            if (neg) begin
                x = mc;
                y = md;
                z = QUARTER_TURN;
            end else begin
                x = md;
                y = mc;
                z = 0;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_STEP[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_STEP[i];
                end
            end
            if (z < 0) z = 0;
            if (z > HALF_TURN) z = HALF_TURN;
            zu = z;
            if (unit_deg) res = (zu * DEG_SCALE_Q24 + (64'd1 << 45)) >> 46;
            else res = (zu + (64'd1 << 15)) >> 16;
            r.angle = res[ANGLE_W-1:0];
            r.degen = 1'b0;
            return r;
        endfunction

        function void note_pair(pair_t p);
            expected_angles.push_back(predict_angle(p));
        endfunction

        function void check_result(logic [ANGLE_W-1:0] angle, logic degen);
            angle_res_t want;
            if (expected_angles.size() == 0) begin
                $display("%0t: result with nothing expected, angle %0d degenerate %0d",
                         $time, angle, degen);
                errors++;
                return;
            end
            want = expected_angles.pop_front();
            if (angle !== want.angle) begin
                $display("%0t: angle mismatch, expected %0d, actual %0d",
                         $time, want.angle, angle);
                errors++;
            end
            if (degen !== want.degen) begin
                $display("%0t: degenerate mismatch, expected %0d, actual %0d",
                         $time, want.degen, degen);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_angles.size();
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_wdata   = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata  = '0;   // first_x, first_y, second_x, second_y
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ANGLE_W-1:0] m_axis_tdata;         // angle
    logic               m_axis_tuser;         // degenerate

    angle_scoreboard sb = new();
    int              n_sent;
    int              n_recv;

    // corner pairs: ax, ay, bx, by
    int corner_tbl [CORNER_COUNT][4] = '{
        '{0, 0, 5, 7},                '{3, -4, 0, 0},
        '{0, 0, 0, 0},                '{-5, 0, 0, 0},
        '{32767, 0, 32767, 0},        '{32767, 0, -32768, 0},
        '{-32768, -32768, -32768, -32768},
        '{-32768, -32768, 32767, 32767},
        '{1, 0, 0, 1},                '{1, 0, 0, -1},
        '{-32768, 32767, 32767, -32768},
        '{32767, -32768, 32767, 32767},
        '{1, 1, -1, 0},               '{-1, 0, 1, 1},
        '{1, 0, 1, 1},                '{32767, 1, 32767, 0},
        '{-32768, 0, -32768, 1},      '{-32768, 0, 32767, 1},
        '{0, -32768, 0, 32767},       '{1, -1, -1, -1},
        '{-1, -1, -1, -1},            '{0, 1, -32768, -32768}
    };

    vector_pair_angle DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // random vector pair, mostly well-spread with a share of special shapes
    function automatic pair_t random_pair();
        pair_t p;
        int    pick;
        int    k;
        int    extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};
        pick = $urandom_range(99);
        p = {$urandom(), $urandom()};
        if (pick < 40) begin
            // full range as drawn
        end else if (pick < 55) begin
            p.ax = 16'(int'($urandom_range(16)) - 8);
            p.ay = 16'(int'($urandom_range(16)) - 8);
            p.bx = 16'(int'($urandom_range(16)) - 8);
            p.by = 16'(int'($urandom_range(16)) - 8);
        end else if (pick < 75) begin
            // nearly parallel or antiparallel
            p.ax = 16'(int'($urandom_range(4000)) - 2000);
            p.ay = 16'(int'($urandom_range(4000)) - 2000);
            k = int'($urandom_range(15)) + 1;
            if ($urandom_range(1)) k = -k;
            p.bx = 16'(int'(p.ax) * k + int'($urandom_range(4)) - 2);
            p.by = 16'(int'(p.ay) * k + int'($urandom_range(4)) - 2);
        end else if (pick < 85) begin
            p.ax = 16'(extremes[$urandom_range(5)]);
            p.ay = 16'(extremes[$urandom_range(5)]);
            p.bx = 16'(extremes[$urandom_range(5)]);
            p.by = 16'(extremes[$urandom_range(5)]);
        end else if (pick < 94) begin
            // axis aligned components
            if ($urandom_range(1)) p.ax = '0;
            if ($urandom_range(1)) p.ay = '0;
            if ($urandom_range(1)) p.bx = '0;
            if ($urandom_range(1)) p.by = '0;
        end else if ($urandom_range(1)) begin
            p.ax = '0;
            p.ay = '0;
        end else begin
            p.bx = '0;
            p.by = '0;
        end
        return p;
    endfunction

    // offer one pair, with random idle cycles first, and wait for the beat
    task automatic send_pair(pair_t p);
        while (!(n_sent >= SEND_CALM_LO && n_sent < SEND_CALM_HI) &&
               $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pair(p);
        n_sent++;
    endtask

    // stop sending, let every expected result arrive, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_unit(bit deg);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= deg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.unit_deg = deg;
    endtask

    // receiver: checks each result beat and stalls at random
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
                n_recv++;
                if (n_recv == HOLD_AT) begin
                    // long hold-off so the pipeline fills and backs up the input
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
            end
            m_axis_tready <= (n_recv >= RECV_CALM_LO && n_recv < RECV_CALM_HI) ||
                             ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // main sequence: corner pairs in both units, then random phases
    initial begin
        pair_t p;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int u = 0; u < 2; u++) begin
            set_unit(u[0]);
            for (int i = 0; i < CORNER_COUNT; i++) begin
                p.ax = 16'(corner_tbl[i][0]);
                p.ay = 16'(corner_tbl[i][1]);
                p.bx = 16'(corner_tbl[i][2]);
                p.by = 16'(corner_tbl[i][3]);
                send_pair(p);
            end
            drain();
        end
        for (int ph = 0; ph < 5; ph++) begin
            set_unit(ph[0]);
            repeat (PHASE_ITEMS) send_pair(random_pair());
            drain();
        end
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("vector_pair_angle regression: pass");
        else
            $display("vector_pair_angle regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("vector_pair_angle regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vpa_pkg.sv
design/vpa_front.sv
design/vpa_norm_cell.sv
design/vpa_cordic_cell.sv
design/vpa_scale.sv
design/vector_pair_angle.sv
design/vpa_checker.sv
dv/tb.sv
